// ----- src/hrf_pkg.sv -----
// Package for the HTTP request framer: widths, codes, match texts and the
// classified-item types shared by the front, the queue and the back.
// No dependencies.
package hrf_pkg;

  // Fixed field widths
  localparam int DATA_W  = 8;
  localparam int ROUTE_W = 2;
  localparam int LEN_W   = 15;

  // Route codes
  localparam logic [ROUTE_W-1:0] ROUTE_READY    = 2'd0;
  localparam logic [ROUTE_W-1:0] ROUTE_FRAUD    = 2'd1;
  localparam logic [ROUTE_W-1:0] ROUTE_NOTFOUND = 2'd2;
  localparam logic [ROUTE_W-1:0] ROUTE_OVERSIZE = 2'd3;

  // Match texts
  localparam int KEY_LEN  = 15;
  localparam int GET_LEN  = 11;
  localparam int POST_LEN = 18;
  localparam int KPOS_W   = $clog2(KEY_LEN + 1);
  localparam int GIDX_W   = $clog2(GET_LEN);
  localparam int PIDX_W   = $clog2(POST_LEN);

  localparam logic [DATA_W-1:0] KEY_TEXT [KEY_LEN] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h", ":"
  };
  localparam logic [DATA_W-1:0] GET_TEXT [GET_LEN] = '{
    "G", "E", "T", " ", "/", "r", "e", "a", "d", "y", " "
  };
  localparam logic [DATA_W-1:0] POST_TEXT [POST_LEN] = '{
    "P", "O", "S", "T", " ", "/", "f", "r", "a", "u", "d", "-", "s", "c", "o",
    "r", "e", " "
  };

  // Characters the parser reacts to
  localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [DATA_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [DATA_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [DATA_W-1:0] CASE_GAP   = 8'h20;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Content-length scanner state
  typedef enum logic [2:0] {
    MODE_FIRST,
    MODE_KEY,
    MODE_SKIP,
    MODE_BLANKS,
    MODE_DIGITS,
    MODE_DONE
  } line_mode_t;

  // One byte after classification
  typedef struct packed {
    logic                fresh_start;
    logic                is_cr;
    logic                is_lf;
    logic                is_blank;
    logic                is_digit;
    logic [3:0]          digit;
    logic [KEY_LEN-1:0]  key_eq;
    logic [GET_LEN-1:0]  get_eq;
    logic [POST_LEN-1:0] post_eq;
  } cls_t;

  // Queue read side toward the back
  typedef struct packed {
    logic valid;
    cls_t item;
  } q_rd_t;

  // Candidate bits to route: ready probe wins over fraud post
  function automatic logic [ROUTE_W-1:0] route_of(input logic [1:0] cand);
    logic [ROUTE_W-1:0] r;
    if (cand[0]) r = ROUTE_READY;
    else if (cand[1]) r = ROUTE_FRAUD;
    else r = ROUTE_NOTFOUND;
    return r;
  endfunction

endpackage

// ----- src/hrf_in_if.sv -----
// Input channel of the HTTP request framer: one request byte per item.
// Depends on hrf_pkg.
interface hrf_in_if;
  logic                      valid;
  logic                      ready;
  logic [hrf_pkg::DATA_W-1:0] data_byte;
  logic                      fresh_start;

  modport source (output valid, output data_byte, output fresh_start, input ready);
  modport sink (input valid, input data_byte, input fresh_start, output ready);
endinterface

// ----- src/hrf_out_if.sv -----
// Result channel of the HTTP request framer: one framed request per item.
// Depends on hrf_pkg.
interface hrf_out_if;
  logic                       valid;
  logic                       ready;
  logic [hrf_pkg::ROUTE_W-1:0] route;
  logic [hrf_pkg::LEN_W-1:0]   header_length;
  logic [hrf_pkg::LEN_W-1:0]   body_length;

  modport source (output valid, output route, output header_length, output body_length,
                  input ready);
  modport sink (input valid, input route, input header_length, input body_length,
                output ready);
endinterface

// ----- src/hrf_front.sv -----
// Front of the framer: accepts bytes and classifies them against the match
// texts and character classes. Depends on hrf_pkg and hrf_in_if.
module hrf_front (
  hrf_in_if.sink        in_chan,
  input  logic          q_full,
  output logic          push,
  output hrf_pkg::cls_t item
);

  logic [hrf_pkg::DATA_W-1:0] b;
  logic [hrf_pkg::DATA_W-1:0] low;
  logic [hrf_pkg::DATA_W-1:0] dval;

  // Accept whenever the queue has room
  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  // Classify the byte
  always_comb begin
    b    = in_chan.data_byte;
    low  = (b >= hrf_pkg::CHAR_UP_A && b <= hrf_pkg::CHAR_UP_Z) ? b + hrf_pkg::CASE_GAP : b;
    dval = b - hrf_pkg::CHAR_ZERO;
    item.fresh_start = in_chan.fresh_start;
    item.is_cr       = (b == hrf_pkg::CHAR_CR);
    item.is_lf       = (b == hrf_pkg::CHAR_LF);
    item.is_blank    = (b == hrf_pkg::CHAR_SPACE) || (b == hrf_pkg::CHAR_TAB);
    item.is_digit    = (b >= hrf_pkg::CHAR_ZERO) && (b <= hrf_pkg::CHAR_NINE);
    item.digit       = dval[3:0];
    for (int i = 0; i < hrf_pkg::KEY_LEN; i++) begin
      item.key_eq[i] = (low == hrf_pkg::KEY_TEXT[i]);
    end
    for (int i = 0; i < hrf_pkg::GET_LEN; i++) begin
      item.get_eq[i] = (b == hrf_pkg::GET_TEXT[i]);
    end
    for (int i = 0; i < hrf_pkg::POST_LEN; i++) begin
      item.post_eq[i] = (b == hrf_pkg::POST_TEXT[i]);
    end
  end

endmodule

// ----- src/hrf_queue.sv -----
// Short queue of classified bytes between the front and the back.
// Depends on hrf_pkg.
module hrf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hrf_pkg::cls_t  item,
  input  logic           pop,
  output logic           full,
  output hrf_pkg::q_rd_t q_rd
);

  hrf_pkg::cls_t                  mem_r [hrf_pkg::QUEUE_DEPTH];
  logic [hrf_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [hrf_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [hrf_pkg::QCNT_W-1:0]     count_r, count_nxt;

  localparam logic [hrf_pkg::QPTR_W-1:0] LAST = hrf_pkg::QPTR_W'(hrf_pkg::QUEUE_DEPTH - 1);

  assign full       = (count_r == hrf_pkg::QCNT_W'(hrf_pkg::QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.item  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= item;
  end

endmodule

// ----- src/hrf_back.sv -----
// Back of the framer: runs the header, length and body parse on classified
// bytes and holds the result register. Depends on hrf_pkg and hrf_out_if.
module hrf_back #(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hrf_pkg::q_rd_t q_rd,
  output logic           q_pop,
  hrf_out_if.source      out_chan
);

  localparam int CW = $clog2(BUFFER_BYTES + 2);
  localparam int VW = CW + 4;
  localparam logic [CW-1:0] LIMIT = CW'(BUFFER_BYTES);
  localparam logic [CW-1:0] SAT   = CW'(BUFFER_BYTES + 1);
  localparam logic [hrf_pkg::KPOS_W-1:0] KEY_LAST = hrf_pkg::KPOS_W'(hrf_pkg::KEY_LEN - 1);
  localparam logic [hrf_pkg::KPOS_W-1:0] KEY_END  = hrf_pkg::KPOS_W'(hrf_pkg::KEY_LEN);

  // Parse state
  logic [1:0]                 blp_r, blp_nxt;
  logic [CW-1:0]              hc_r, hc_nxt;
  logic [hrf_pkg::KPOS_W-1:0] lp_r, lp_nxt;
  hrf_pkg::line_mode_t        mode_r, mode_nxt;
  logic                       found_r, found_nxt;
  logic [CW-1:0]              len_r, len_nxt;
  logic [1:0]                 cand_r, cand_nxt;
  logic                       in_body_r, in_body_nxt;
  logic [CW-1:0]              body_r, body_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [hrf_pkg::ROUTE_W-1:0] out_route_r, out_route_nxt;
  logic [hrf_pkg::LEN_W-1:0]   out_hlen_r, out_hlen_nxt;
  logic [hrf_pkg::LEN_W-1:0]   out_blen_r, out_blen_nxt;

  // State seen by the current byte, after an optional fresh start
  hrf_pkg::cls_t              cls;
  logic [1:0]                 blp_cur;
  logic [CW-1:0]              hc_cur;
  logic [hrf_pkg::KPOS_W-1:0] lp_cur;
  hrf_pkg::line_mode_t        mode_cur;
  logic                       found_cur;
  logic [CW-1:0]              len_cur;
  logic [1:0]                 cand_cur;
  logic                       in_body_cur;
  logic [CW-1:0]              body_cur;

  // Scanner results
  hrf_pkg::line_mode_t        mode_scan;
  logic [hrf_pkg::KPOS_W-1:0] lp_scan;
  logic                       found_scan;
  logic [CW-1:0]              len_scan;
  logic                       key_hit;
  logic                       scan_en;
  logic [VW-1:0]              len_mul;
  logic [CW-1:0]              len_dig;

  // Step signals
  logic                        emit;
  logic [hrf_pkg::ROUTE_W-1:0] e_route;
  logic [CW-1:0]               e_hlen;
  logic [CW-1:0]               e_blen;
  logic [CW-1:0]               hc1;
  logic [CW-1:0]               body1;
  logic [CW:0]                 total;
  logic                        end_found;

  assign cls   = q_rd.item;
  assign q_pop = q_rd.valid && (!out_valid_r || out_chan.ready);

  // Apply a fresh start before the byte
  always_comb begin
    if (cls.fresh_start) begin
      blp_cur     = '0;
      hc_cur      = '0;
      lp_cur      = '0;
      mode_cur    = hrf_pkg::MODE_FIRST;
      found_cur   = 1'b0;
      len_cur     = '0;
      cand_cur    = 2'b11;
      in_body_cur = 1'b0;
      body_cur    = '0;
    end else begin
      blp_cur     = blp_r;
      hc_cur      = hc_r;
      lp_cur      = lp_r;
      mode_cur    = mode_r;
      found_cur   = found_r;
      len_cur     = len_r;
      cand_cur    = cand_r;
      in_body_cur = in_body_r;
      body_cur    = body_r;
    end
  end

  assign key_hit = (lp_cur < KEY_END) && cls.key_eq[lp_cur];
  assign scan_en = !found_cur || (mode_cur == hrf_pkg::MODE_BLANKS) ||
                   (mode_cur == hrf_pkg::MODE_DIGITS);

  // Take one decimal digit, saturate above the buffer size
  always_comb begin
    len_mul = (VW'(len_cur) << 3) + (VW'(len_cur) << 1) + VW'(cls.digit);
    len_dig = (len_mul > VW'(BUFFER_BYTES)) ? SAT : len_mul[CW-1:0];
  end

  // Scanner next state
  always_comb begin
    mode_scan = mode_cur;
    unique case (mode_cur)
      hrf_pkg::MODE_FIRST, hrf_pkg::MODE_SKIP: begin
        if (cls.is_lf) mode_scan = hrf_pkg::MODE_KEY;
      end
      hrf_pkg::MODE_KEY: begin
        if (cls.is_lf) mode_scan = hrf_pkg::MODE_KEY;
        else if (key_hit) begin
          if (lp_cur == KEY_LAST) mode_scan = hrf_pkg::MODE_BLANKS;
        end else mode_scan = hrf_pkg::MODE_SKIP;
      end
      hrf_pkg::MODE_BLANKS, hrf_pkg::MODE_DIGITS: begin
        if (mode_cur == hrf_pkg::MODE_BLANKS && cls.is_blank) mode_scan = mode_cur;
        else if (cls.is_digit) mode_scan = hrf_pkg::MODE_DIGITS;
        else mode_scan = hrf_pkg::MODE_DONE;
      end
      hrf_pkg::MODE_DONE: mode_scan = mode_cur;
      default: mode_scan = mode_cur;
    endcase
  end

  // Scanner outputs: key position and length value
  always_comb begin
    lp_scan    = lp_cur;
    found_scan = found_cur;
    len_scan   = len_cur;
    unique case (mode_cur)
      hrf_pkg::MODE_FIRST, hrf_pkg::MODE_SKIP: begin
        if (cls.is_lf) lp_scan = '0;
      end
      hrf_pkg::MODE_KEY: begin
        if (cls.is_lf) lp_scan = '0;
        else if (key_hit) begin
          lp_scan = lp_cur + 1'b1;
          if (lp_cur == KEY_LAST) begin
            found_scan = 1'b1;
            len_scan   = '0;
          end
        end
      end
      hrf_pkg::MODE_BLANKS, hrf_pkg::MODE_DIGITS: begin
        if (!(mode_cur == hrf_pkg::MODE_BLANKS && cls.is_blank) && cls.is_digit) begin
          len_scan = len_dig;
        end
      end
      hrf_pkg::MODE_DONE: len_scan = len_cur;
      default: len_scan = len_cur;
    endcase
  end

  // One byte: header tracking, body counting, result and restart
  always_comb begin
    blp_nxt     = blp_r;
    hc_nxt      = hc_r;
    lp_nxt      = lp_r;
    mode_nxt    = mode_r;
    found_nxt   = found_r;
    len_nxt     = len_r;
    cand_nxt    = cand_r;
    in_body_nxt = in_body_r;
    body_nxt    = body_r;
    emit        = 1'b0;
    e_route     = hrf_pkg::ROUTE_OVERSIZE;
    e_hlen      = '0;
    e_blen      = '0;
    hc1         = hc_cur + 1'b1;
    body1       = body_cur + 1'b1;
    total       = '0;
    end_found   = 1'b0;
    if (q_pop) begin
      blp_nxt     = blp_cur;
      hc_nxt      = hc_cur;
      lp_nxt      = lp_cur;
      mode_nxt    = mode_cur;
      found_nxt   = found_cur;
      len_nxt     = len_cur;
      cand_nxt    = cand_cur;
      in_body_nxt = in_body_cur;
      body_nxt    = body_cur;
      if (in_body_cur) begin
        body_nxt = body1;
        if (body1 >= len_cur) begin
          emit    = 1'b1;
          e_route = hrf_pkg::route_of(cand_cur);
          e_hlen  = hc_cur;
          e_blen  = len_cur;
        end
      end else begin
        // Drop route candidates on a mismatch in the request line
        if (hc_cur < CW'(hrf_pkg::GET_LEN) && !cls.get_eq[hc_cur[hrf_pkg::GIDX_W-1:0]])
          cand_nxt[0] = 1'b0;
        if (hc_cur < CW'(hrf_pkg::POST_LEN) && !cls.post_eq[hc_cur[hrf_pkg::PIDX_W-1:0]])
          cand_nxt[1] = 1'b0;
        // Track the blank line
        if (cls.is_cr) blp_nxt = (blp_cur == 2'd2) ? 2'd3 : 2'd1;
        else if (cls.is_lf) begin
          end_found = (blp_cur == 2'd3);
          blp_nxt   = (blp_cur == 2'd1) ? 2'd2 : 2'd0;
        end else blp_nxt = 2'd0;
        if (scan_en) begin
          mode_nxt  = mode_scan;
          lp_nxt    = lp_scan;
          found_nxt = found_scan;
          len_nxt   = len_scan;
        end
        hc_nxt = hc1;
        total  = {1'b0, hc1} + {1'b0, len_nxt};
        if (end_found) begin
          if (len_nxt > LIMIT || total > {1'b0, LIMIT}) begin
            emit   = 1'b1;
            e_hlen = hc1;
          end else if (len_nxt == '0) begin
            emit    = 1'b1;
            e_route = hrf_pkg::route_of(cand_nxt);
            e_hlen  = hc1;
          end else begin
            in_body_nxt = 1'b1;
            body_nxt    = '0;
          end
        end else if (hc1 >= LIMIT) begin
          emit   = 1'b1;
          e_hlen = hc1;
        end
      end
      // Restart parsing after a result
      if (emit) begin
        blp_nxt     = '0;
        hc_nxt      = '0;
        lp_nxt      = '0;
        mode_nxt    = hrf_pkg::MODE_FIRST;
        found_nxt   = 1'b0;
        len_nxt     = '0;
        cand_nxt    = 2'b11;
        in_body_nxt = 1'b0;
        body_nxt    = '0;
      end
    end
  end

  // Load or release the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_route_nxt = out_route_r;
    out_hlen_nxt  = out_hlen_r;
    out_blen_nxt  = out_blen_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_route_nxt = e_route;
      out_hlen_nxt  = hrf_pkg::LEN_W'(e_hlen);
      out_blen_nxt  = hrf_pkg::LEN_W'(e_blen);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blp_r       <= '0;
      hc_r        <= '0;
      lp_r        <= '0;
      mode_r      <= hrf_pkg::MODE_FIRST;
      found_r     <= 1'b0;
      len_r       <= '0;
      cand_r      <= 2'b11;
      in_body_r   <= 1'b0;
      body_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      blp_r       <= blp_nxt;
      hc_r        <= hc_nxt;
      lp_r        <= lp_nxt;
      mode_r      <= mode_nxt;
      found_r     <= found_nxt;
      len_r       <= len_nxt;
      cand_r      <= cand_nxt;
      in_body_r   <= in_body_nxt;
      body_r      <= body_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_route_r <= out_route_nxt;
    out_hlen_r  <= out_hlen_nxt;
    out_blen_r  <= out_blen_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.route         = out_route_r;
  assign out_chan.header_length = out_hlen_r;
  assign out_chan.body_length   = out_blen_r;

endmodule

// ----- src/http_request_framer.sv -----
// Top level of the HTTP/1.1 request framer with Content-Length framing.
// Depends on hrf_pkg, hrf_in_if, hrf_out_if, hrf_front, hrf_queue, hrf_back.
//
//   channel    dir  payload                                  handshake
//   in_chan    in   data_byte[7:0], fresh_start              valid/ready
//   out_chan   out  route[1:0], header_length[14:0],         valid/ready
//                   body_length[14:0]
//
// One byte per cycle sustained while results are taken; the back parses one
// queued byte per cycle unless an unread result stalls it.
// The two-entry byte queue absorbs a stall of the result register, so
// in_chan stays ready while an unread result waits and the queue has room.
// rst_n is synchronous and clears the queue, parse state and result valid.
module http_request_framer #(
  parameter int BUFFER_BYTES = 16384
) (
  input  logic      clk,
  input  logic      rst_n,
  hrf_in_if.sink    in_chan,
  hrf_out_if.source out_chan
);

  logic           q_full;
  logic           push;
  hrf_pkg::cls_t  item;
  logic           q_pop;
  hrf_pkg::q_rd_t q_rd;

  // Classify incoming bytes
  hrf_front u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .item    (item)
  );

  // Decouple front and back
  hrf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .item  (item),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  // Parse and frame
  hrf_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rd     (q_rd),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_rd.valid)
    else $error("pop from empty byte queue");

  a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(q_pop))
    else $error("result appeared without a parsed byte");

  a_oversize_no_body: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.route == hrf_pkg::ROUTE_OVERSIZE) |->
      (out_chan.body_length == '0))
    else $error("oversize result carries a body length");
`endif

endmodule
